>>> design/gqr_pkg.sv
// ----------------------------------------------------------------------------
// gqr_pkg
// shared widths, codes, token type and helpers for the givens qr block
// ----------------------------------------------------------------------------
package gqr_pkg;

	localparam int IDX_W     = 2;   // row / column index ports
	localparam int DIM_W     = 3;   // matrix size and loop counters
	localparam int WORD_W    = 32;  // matrix word
	localparam int CS_W      = 26;  // rotation coefficient, covers fraction up to 24 bits
	localparam int THR_W     = 17;  // zero threshold
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR  = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ROT,
		OP_NEG,
		OP_THR
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        j;
		logic [IDX_W-1:0]        i;
		logic signed [CS_W-1:0]  c;
		logic signed [CS_W-1:0]  s;
	} tok_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PICK,
		ST_SQ,
		ST_SUM,
		ST_ROOT_GO,
		ST_ROOT,
		ST_DIVC_GO,
		ST_DIVC,
		ST_DIVS_GO,
		ST_DIVS,
		ST_ISSUE,
		ST_DRAIN,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// magnitude as unsigned, most negative word gives 2^31
	function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
		return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
	endfunction

endpackage

>>> design/gqr_sqrt.sv
// ----------------------------------------------------------------------------
// gqr_sqrt
// integer square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module gqr_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;
	logic        take;

	assign trial = res_q + bit_q;
	assign take  = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (take) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

>>> design/gqr_div.sv
// ----------------------------------------------------------------------------
// gqr_div
// restoring divide of (mag << FRAC_BITS) by den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gqr_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          mag,
	input  logic [31:0]          den,
	output logic                 done,
	output logic [FRAC_BITS:0]   quo
);
	localparam int QW = FRAC_BITS + 1;
	localparam int CW = $clog2(QW + 1);

	logic [31:0]    rem_q;
	logic [31:0]    den_q;
	logic [QW-1:0]  low_q;
	logic [QW-1:0]  quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [32:0]    sh;
	logic           ge;

	// quotient is below 2^QW, so the top of the dividend already sits below den
	assign sh = {rem_q, low_q[QW-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, mag[31:1]};
			low_q <= QW'(mag[0]) << FRAC_BITS;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(sh - {1'b0, den_q}) : sh[31:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> design/gqr_cell.sv
// ----------------------------------------------------------------------------
// gqr_cell
// one cell of the chain: column CELL_IDX of R and row CELL_IDX of Q
// ----------------------------------------------------------------------------
module gqr_cell #(
	parameter int CELL_IDX  = 0,
	parameter int MAX_DIM   = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gqr_pkg::tok_t                         tok_in,
	output gqr_pkg::tok_t                         tok_out,
	input  logic                                  wr_en,
	input  logic [gqr_pkg::IDX_W-1:0]             wr_row,
	input  logic signed [gqr_pkg::WORD_W-1:0]     wr_value,
	input  logic                                  q_init,
	input  logic [gqr_pkg::DIM_W-1:0]             n,
	input  logic [gqr_pkg::DIM_W-1:0]             m,
	input  logic [gqr_pkg::THR_W-1:0]             thr,
	output logic signed [gqr_pkg::WORD_W-1:0]     r_word [MAX_DIM],
	output logic signed [gqr_pkg::WORD_W-1:0]     q_word [MAX_DIM]
);
	import gqr_pkg::*;

	localparam int AW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int PW = WORD_W + CS_W;
	localparam int SW = PW + 1;
	localparam logic [DIM_W-1:0]         MY   = DIM_W'(CELL_IDX);
	localparam logic signed [WORD_W-1:0] ONE  = WORD_W'(64'd1 << FRAC_BITS);
	localparam logic signed [SW-1:0]     HALF = SW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [SW-1:0]     SMAX = SW'(WORD_MAX);
	localparam logic signed [SW-1:0]     SMIN = SW'(WORD_MIN);

	logic signed [WORD_W-1:0] r_q [MAX_DIM];
	logic signed [WORD_W-1:0] q_q [MAX_DIM];
	tok_t                     tok_s1;
	logic signed [PW-1:0]     rcx_s1, rsy_s1, rsx_s1, rcy_s1;
	logic signed [PW-1:0]     qcx_s1, qsy_s1, qsx_s1, qcy_s1;
	logic [AW-1:0]            ja, ia, jb, ib;
	logic signed [SW-1:0]     acc_rx, acc_ry, acc_qx, acc_qy;
	logic                     in_r, in_q;

	function automatic logic signed [WORD_W-1:0] scale_down(input logic signed [SW-1:0] acc);
		logic signed [SW-1:0] sh;
		sh = (acc + HALF) >>> FRAC_BITS;
		if (sh > SMAX)
			return WORD_MAX;
		else if (sh < SMIN)
			return WORD_MIN;
		else
			return sh[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] neg_sat(input logic signed [WORD_W-1:0] v);
		return (v == WORD_MIN) ? WORD_MAX : -v;
	endfunction

	assign ja = tok_in.j[AW-1:0];
	assign ia = tok_in.i[AW-1:0];
	assign jb = tok_s1.j[AW-1:0];
	assign ib = tok_s1.i[AW-1:0];

	// stage 1: products of the pair this token touches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		rcx_s1 <= PW'(tok_in.c) * PW'(r_q[ja]);
		rsy_s1 <= PW'(tok_in.s) * PW'(r_q[ia]);
		rsx_s1 <= PW'(tok_in.s) * PW'(r_q[ja]);
		rcy_s1 <= PW'(tok_in.c) * PW'(r_q[ia]);
		qcx_s1 <= PW'(tok_in.c) * PW'(q_q[ja]);
		qsy_s1 <= PW'(tok_in.s) * PW'(q_q[ia]);
		qsx_s1 <= PW'(tok_in.s) * PW'(q_q[ja]);
		qcy_s1 <= PW'(tok_in.c) * PW'(q_q[ia]);
	end

	// stage 2: sums, rounding and write back
	assign acc_rx = SW'(rcx_s1) - SW'(rsy_s1);
	assign acc_ry = SW'(rsx_s1) + SW'(rcy_s1);
	assign acc_qx = SW'(qcx_s1) - SW'(qsy_s1);
	assign acc_qy = SW'(qsx_s1) + SW'(qcy_s1);
	assign in_r   = (MY >= DIM_W'(tok_s1.j)) && (MY < m);
	assign in_q   = MY < n;

	always_ff @(posedge clk) begin
		if (wr_en)
			r_q[wr_row[AW-1:0]] <= wr_value;
		if (q_init) begin
			for (int e = 0; e < MAX_DIM; e++)
				q_q[e] <= (e == CELL_IDX) ? ONE : '0;
		end
		case (tok_s1.op)
			OP_ROT: begin
				if (in_r) begin
					r_q[jb] <= scale_down(acc_rx);
					r_q[ib] <= scale_down(acc_ry);
				end
				if (in_q) begin
					q_q[jb] <= scale_down(acc_qx);
					q_q[ib] <= scale_down(acc_qy);
				end
			end
			OP_NEG: begin
				if (in_r)
					r_q[jb] <= neg_sat(r_q[jb]);
				if (in_q)
					q_q[jb] <= neg_sat(q_q[jb]);
			end
			OP_THR: begin
				for (int e = 0; e < MAX_DIM; e++) begin
					if (e > CELL_IDX && DIM_W'(e) < n && MY < m
					    && mag(r_q[e]) < WORD_W'(thr))
						r_q[e] <= '0;
				end
			end
			default: ;
		endcase
	end

	assign tok_out = tok_s1;
	assign r_word  = r_q;
	assign q_word  = q_q;

endmodule

>>> design/givens_qr_decomposition.sv
// ----------------------------------------------------------------------------
// givens_qr_decomposition
// qr decomposition by givens rotations on a chain of column cells
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_ready   row_index, col_index, element_value,
//                                             last_element
//  out       from block out_valid / out_ready which_matrix, out_row, out_col,
//                                             out_value, last_result
//  cfg       to block   cfg_wr_en             cfg_index, cfg_data
//
//  loading takes one element item per cycle
//  an item flagged last starts the decomposition; each rotation runs a
//  32-step root and two bit-serial divides (skipped when the lower entry
//  is zero), then the token walks the cell chain; six rotations for a
//  4 by 4 matrix
//  then one result item per cycle while out_ready is high
//  in_ready is low from the start of a decomposition until its final item
//  has been moved into the output register
//  reset clears control state and sets rows and cols to 4, threshold to 0
// ----------------------------------------------------------------------------
module givens_qr_decomposition #(
	parameter int MAX_DIM   = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [gqr_pkg::IDX_W-1:0]             row_index,
	input  logic [gqr_pkg::IDX_W-1:0]             col_index,
	input  logic signed [gqr_pkg::WORD_W-1:0]     element_value,
	input  logic                                  last_element,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  which_matrix,
	output logic [gqr_pkg::IDX_W-1:0]             out_row,
	output logic [gqr_pkg::IDX_W-1:0]             out_col,
	output logic signed [gqr_pkg::WORD_W-1:0]     out_value,
	output logic                                  last_result,
	input  logic                                  cfg_wr_en,
	input  logic [gqr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [gqr_pkg::CFG_W-1:0]             cfg_data
);
	import gqr_pkg::*;

	localparam int AW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int QW = FRAC_BITS + 1;
	localparam logic [DIM_W-1:0]       DIM_MAX = DIM_W'(MAX_DIM);
	localparam logic signed [CS_W-1:0] ONE_CS  = CS_W'(64'd1 << FRAC_BITS);

	// configuration
	logic [DIM_W-1:0] rows_q, cols_q;
	logic [THR_W-1:0] thr_q;

	// sequencer
	state_t           state_q, state_d, ret_q;
	op_t              op_q;
	logic [DIM_W-1:0] n_q, m_q, j_q, i_q, cnt_q;
	logic [DIM_W-1:0] n_start, m_start;
	logic [DIM_W-1:0] er_q, ec_q;
	logic             which_q;

	// rotation datapath
	logic             a_neg_q, b_neg_q;
	logic [WORD_W-1:0] ma_q, mb_q;
	logic [63:0]      sqa_q, sqb_q, sum_q;
	logic [31:0]      root_q, sqrt_root;
	logic signed [CS_W-1:0] c_q, s_q;
	logic             sqrt_start, sqrt_done;
	logic             div_start, div_done;
	logic [31:0]      div_mag;
	logic [QW-1:0]    div_quo;

	// output register
	logic             out_valid_q;
	logic             which_o_q, last_o_q;
	logic [IDX_W-1:0] row_o_q, col_o_q;
	logic signed [WORD_W-1:0] val_o_q;

	// cell chain
	tok_t                     tok_chain [MAX_DIM+1];
	tok_t                     tok_issue;
	logic signed [WORD_W-1:0] cell_r [MAX_DIM][MAX_DIM];
	logic signed [WORD_W-1:0] cell_q [MAX_DIM][MAX_DIM];

	logic                     in_acc, q_init, emit_load, emit_last, emit_row_end;
	logic signed [WORD_W-1:0] diag_a, sub_b, diag_i, emit_val;
	logic [DIM_W-1:0]         emit_lim;

	assign in_ready = (state_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign q_init   = in_acc && last_element;

	// size clamp: n to 1..MAX_DIM, m to 1..n
	always_comb begin
		if (rows_q == '0)
			n_start = DIM_W'(1);
		else if (rows_q > DIM_MAX)
			n_start = DIM_MAX;
		else
			n_start = rows_q;
		if (cols_q == '0)
			m_start = DIM_W'(1);
		else if (cols_q > n_start)
			m_start = n_start;
		else
			m_start = cols_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
			thr_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data[DIM_W-1:0];
				REG_COLS: cols_q <= cfg_data[DIM_W-1:0];
				REG_THR:  thr_q  <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// the chain: a token enters cell 0 and moves one cell per cycle
	assign tok_chain[0] = tok_issue;

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		logic wr_en;
		assign wr_en = in_acc && (col_index == IDX_W'(k))
		               && ({1'b0, row_index} < DIM_MAX)
		               && ({1'b0, col_index} < DIM_MAX);
		gqr_cell #(
			.CELL_IDX  (k),
			.MAX_DIM   (MAX_DIM),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_chain[k]),
			.tok_out  (tok_chain[k+1]),
			.wr_en    (wr_en),
			.wr_row   (row_index),
			.wr_value (element_value),
			.q_init   (q_init),
			.n        (n_q),
			.m        (m_q),
			.thr      (thr_q),
			.r_word   (cell_r[k]),
			.q_word   (cell_q[k])
		);
	end

	gqr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	gqr_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (div_mag),
		.den    (root_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// R is held column-wise in the cells, Q row-wise
	assign diag_a = cell_r[j_q[AW-1:0]][j_q[AW-1:0]];
	assign sub_b  = cell_r[j_q[AW-1:0]][i_q[AW-1:0]];
	assign diag_i = cell_r[i_q[AW-1:0]][i_q[AW-1:0]];

	assign emit_val     = which_q ? cell_r[ec_q[AW-1:0]][er_q[AW-1:0]]
	                              : cell_q[er_q[AW-1:0]][ec_q[AW-1:0]];
	assign emit_lim     = which_q ? m_q : n_q;
	assign emit_row_end = (ec_q + 1'b1) == emit_lim;
	assign emit_last    = which_q && emit_row_end && ((er_q + 1'b1) == n_q);
	assign div_mag      = (state_q == ST_DIVS_GO) ? mb_q : ma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		tok_issue  = '0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		emit_load  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && last_element)
					state_d = ST_PICK;
			end
			ST_PICK: begin
				if (j_q >= m_q)
					state_d = ST_SIGN;
				else if (i_q < n_q)
					state_d = (sub_b == '0) ? ST_ISSUE : ST_SQ;
			end
			ST_SQ:      state_d = ST_SUM;
			ST_SUM:     state_d = ST_ROOT_GO;
			ST_ROOT_GO: begin
				sqrt_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (sqrt_done)
					state_d = ST_DIVC_GO;
			end
			ST_DIVC_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIVC;
			end
			ST_DIVC: begin
				if (div_done)
					state_d = ST_DIVS_GO;
			end
			ST_DIVS_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIVS;
			end
			ST_DIVS: begin
				if (div_done)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				tok_issue.op = op_q;
				tok_issue.j  = (op_q == OP_NEG) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
				tok_issue.i  = i_q[IDX_W-1:0];
				tok_issue.c  = c_q;
				tok_issue.s  = s_q;
				state_d      = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (cnt_q == '0)
					state_d = ret_q;
			end
			ST_SIGN: begin
				if (i_q >= m_q || diag_i[WORD_W-1])
					state_d = ST_ISSUE;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit_load = 1'b1;
					if (emit_last)
						state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// loop counters and op selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= DIM_RESET;
			m_q     <= DIM_RESET;
			j_q     <= '0;
			i_q     <= '0;
			cnt_q   <= '0;
			op_q    <= OP_NONE;
			ret_q   <= ST_LOAD;
			er_q    <= '0;
			ec_q    <= '0;
			which_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc && last_element) begin
						n_q <= n_start;
						m_q <= m_start;
						j_q <= '0;
						i_q <= DIM_W'(1);
					end
				end
				ST_PICK: begin
					if (j_q >= m_q) begin
						i_q <= '0;
					end else if (i_q >= n_q) begin
						j_q <= j_q + 1'b1;
						i_q <= j_q + DIM_W'(2);
					end else begin
						op_q <= OP_ROT;
					end
				end
				ST_ISSUE: begin
					cnt_q <= DIM_MAX;
					case (op_q)
						OP_ROT: begin
							i_q   <= i_q + 1'b1;
							ret_q <= ST_PICK;
						end
						OP_NEG: begin
							i_q   <= i_q + 1'b1;
							ret_q <= ST_SIGN;
						end
						default: begin
							ret_q   <= ST_EMIT;
							er_q    <= '0;
							ec_q    <= '0;
							which_q <= 1'b0;
						end
					endcase
				end
				ST_DRAIN: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - 1'b1;
				end
				ST_SIGN: begin
					if (i_q >= m_q)
						op_q <= OP_THR;
					else if (diag_i[WORD_W-1])
						op_q <= OP_NEG;
					else
						i_q <= i_q + 1'b1;
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (emit_row_end) begin
							ec_q <= '0;
							if ((er_q + 1'b1) == n_q) begin
								er_q    <= '0;
								which_q <= 1'b1;
							end else begin
								er_q <= er_q + 1'b1;
							end
						end else begin
							ec_q <= ec_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// rotation coefficients: c = sign(a)|a|/r, s = -sign(b)|b|/r
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PICK: begin
				a_neg_q <= diag_a[WORD_W-1];
				b_neg_q <= sub_b[WORD_W-1];
				ma_q    <= mag(diag_a);
				mb_q    <= mag(sub_b);
				if (sub_b == '0) begin
					c_q <= ONE_CS;
					s_q <= '0;
				end
			end
			ST_SQ: begin
				sqa_q <= 64'(ma_q) * 64'(ma_q);
				sqb_q <= 64'(mb_q) * 64'(mb_q);
			end
			ST_SUM: sum_q <= sqa_q + sqb_q;
			ST_ROOT: begin
				if (sqrt_done)
					root_q <= sqrt_root;
			end
			ST_DIVC: begin
				if (div_done)
					c_q <= a_neg_q ? -CS_W'(div_quo) : CS_W'(div_quo);
			end
			ST_DIVS: begin
				if (div_done)
					s_q <= b_neg_q ? CS_W'(div_quo) : -CS_W'(div_quo);
			end
			default: ;
		endcase
	end

	// output register, filled when empty and refilled while the held item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			which_o_q <= which_q;
			row_o_q   <= er_q[IDX_W-1:0];
			col_o_q   <= ec_q[IDX_W-1:0];
			val_o_q   <= emit_val;
			last_o_q  <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign which_matrix = which_o_q;
	assign out_row      = row_o_q;
	assign out_col      = col_o_q;
	assign out_value    = val_o_q;
	assign last_result  = last_o_q;

	// checks
	a_last_is_r: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> which_matrix)
		else $error("last item not an R entry");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok_chain[0].op != OP_NONE |=> tok_chain[0].op == OP_NONE)
		else $error("token issued on consecutive cycles");

	a_chain_empty_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> tok_chain[MAX_DIM].op == OP_NONE)
		else $error("cell chain busy while loading");

	a_root_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_ROOT)
		else $error("square root finished outside its wait state");

endmodule
